// File: rtl/core/mlfq_pkg.sv
`default_nettype none

package mlfq_pkg;

   // Fixed point format: signed 17.14.
   localparam int FP_SHIFT = 14;
   localparam int FP_ONE   = 1 << FP_SHIFT;

   // Scheduler constants.
   localparam int LOAD_DECAY = 16110;
   localparam int LOAD_GAIN  = 273;
   localparam int PRIO_BASE  = 63;

   // Field widths.
   localparam int LA_W   = 24;
   localparam int CPU_W  = 32;
   localparam int NICE_W = 6;
   localparam int RC_W   = 10;
   localparam int VAL_W  = 32;

   // Decay divider: one quotient bit per stage, quotient always below FP_ONE.
   localparam int DIV_STEPS = FP_SHIFT;
   localparam int REM_W     = LA_W + FP_SHIFT + 2;
   localparam int DEN_W     = LA_W + 2;

   // Product of the decay factor and recent CPU.
   localparam int PROD_W = DIV_STEPS + 1 + CPU_W;

   // Register stages from input to result: capture, prepare, divider, multiply, output.
   localparam int LATENCY = DIV_STEPS + 4;

   // Operation codes.
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_RECENT = 2'd1,
      OP_PRIO   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

endpackage

`default_nettype wire

// File: rtl/core/mlfq_sched_stats_unit_core.sv
`default_nettype none

// Scheduler statistics unit in signed 17.14 fixed point. An item is taken at every clock
// edge where start is high and busy is low; busy is high only while reset is applied, so
// one item can enter every cycle. Each item gives exactly one result, shown for one cycle
// with rsp_strobe once it has passed through every register stage of the pipe. Results
// leave in the order that items came in and cannot be held off. The latency is set by
// the decay factor divider, which resolves one quotient bit per stage over 14 stages,
// plus capture, preparation, multiply and output stages. An unused operation code
// gives the value zero.
module mlfq_sched_stats_unit_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_type,
   input  wire logic [mlfq_pkg::LA_W-1:0]     req_load_level,
   input  wire logic signed [mlfq_pkg::CPU_W-1:0] req_cpu_usage,
   input  wire logic signed [mlfq_pkg::NICE_W-1:0] req_nice_value,
   input  wire logic [mlfq_pkg::RC_W-1:0]     req_ready_count,
   output logic                               rsp_strobe,
   output logic signed [mlfq_pkg::VAL_W-1:0]  rsp_value
);
   import mlfq_pkg::*;

   logic accept;

   // Input capture stage.
   logic                     in_valid_ff;
   op_type                   in_op_ff;
   logic [LA_W-1:0]          in_la_ff;
   logic signed [CPU_W-1:0]  in_cpu_ff;
   logic signed [NICE_W-1:0] in_nice_ff;
   logic [RC_W-1:0]          in_rc_ff;

   // Preparation logic.
   logic [LA_W+FP_SHIFT-1:0] load_prod;
   logic [RC_W+9-1:0]        gain_prod;
   logic [VAL_W-1:0]         load_val;
   logic [8:0]               prio_base;
   logic [CPU_W:0]           cpu_bias;
   logic signed [CPU_W+1:0]  prio_num;
   logic signed [CPU_W+1:0]  prio_adj;
   logic [VAL_W-1:0]         prio_val;
   logic [VAL_W-1:0]         alt_in;

   // Divider pipeline; index 0 is the preparation stage.
   logic                     pv_ff   [0:DIV_STEPS];
   op_type                   pop_ff  [0:DIV_STEPS];
   logic signed [CPU_W-1:0]  pcpu_ff [0:DIV_STEPS];
   logic signed [NICE_W-1:0] pnice_ff[0:DIV_STEPS];
   logic [VAL_W-1:0]         palt_ff [0:DIV_STEPS];
   logic [REM_W-1:0]         prem_ff [0:DIV_STEPS];
   logic [DEN_W-1:0]         pden_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0]     pquo_ff [0:DIV_STEPS];

   // Multiply stage.
   logic                     mul_valid_ff;
   op_type                   mul_op_ff;
   logic signed [NICE_W-1:0] mul_nice_ff;
   logic [VAL_W-1:0]         mul_alt_ff;
   logic signed [PROD_W-1:0] mul_prod_ff;
   logic signed [PROD_W-1:0] mul_prod_in;

   // Output stage.
   logic signed [PROD_W-1:0] scaled_adj;
   logic [VAL_W-1:0]         recent_val;
   logic [VAL_W-1:0]         value_in;
   logic                     rsp_strobe_ff;
   logic [VAL_W-1:0]         rsp_value_ff;

   // The unit never stalls; items offered during reset are refused.
   assign busy   = reset;
   assign accept = start && !busy;

   // Capture the incoming item.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
      in_op_ff   <= op_type'(req_type);
      in_la_ff   <= req_load_level;
      in_cpu_ff  <= req_cpu_usage;
      in_nice_ff <= req_nice_value;
      in_rc_ff   <= req_ready_count;
   end

   // Load average: decayed average plus the weighted ready count.
   always_comb begin
      load_prod = (LA_W+FP_SHIFT)'(in_la_ff) * (LA_W+FP_SHIFT)'(LOAD_DECAY);
      gain_prod = (RC_W+9)'(in_rc_ff) * (RC_W+9)'(LOAD_GAIN);
      load_val  = VAL_W'(load_prod[LA_W+FP_SHIFT-1:FP_SHIFT]) + VAL_W'(gain_prod);
   end

   // Priority: base minus twice nice, less a quarter of recent CPU, both truncated.
   always_comb begin
      prio_base = 9'(PRIO_BASE) - {{2{in_nice_ff[NICE_W-1]}}, in_nice_ff, 1'b0};
      cpu_bias  = {in_cpu_ff[CPU_W-1], in_cpu_ff}
                  + {{(CPU_W-1){1'b0}}, in_cpu_ff[CPU_W-1], in_cpu_ff[CPU_W-1]};
      prio_num  = $signed({11'b0, prio_base, {FP_SHIFT{1'b0}}})
                  - $signed({{3{cpu_bias[CPU_W]}}, cpu_bias[CPU_W:2]});
      prio_adj  = prio_num + (prio_num[CPU_W+1] ? (CPU_W+2)'(FP_ONE - 1) : '0);
      prio_val  = {{12{prio_adj[CPU_W+1]}}, prio_adj[CPU_W+1:FP_SHIFT]};
   end

   // Results that need no division travel down the pipe alongside it.
   always_comb begin
      case (in_op_ff)
         OP_LOAD: alt_in = load_val;
         OP_PRIO: alt_in = prio_val;
         default: alt_in = '0;
      endcase
   end

   // Preparation stage: divider operands and the early results.
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff[0] <= 1'b0;
      end else begin
         pv_ff[0] <= in_valid_ff;
      end
      pop_ff[0]   <= in_op_ff;
      pcpu_ff[0]  <= in_cpu_ff;
      pnice_ff[0] <= in_nice_ff;
      palt_ff[0]  <= alt_in;
      prem_ff[0]  <= {1'b0, in_la_ff, {(FP_SHIFT+1){1'b0}}};
      pden_ff[0]  <= {1'b0, in_la_ff, 1'b0} + DEN_W'(FP_ONE);
      pquo_ff[0]  <= '0;
   end

   // Restoring divider, one quotient bit per stage, most significant first.
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      localparam int Bit = DIV_STEPS - 1 - g;
      logic [REM_W-1:0] trial;
      logic             fits;

      assign trial = REM_W'(pden_ff[g]) << Bit;
      assign fits  = (prem_ff[g] >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff[g+1] <= 1'b0;
         end else begin
            pv_ff[g+1] <= pv_ff[g];
         end
         pop_ff[g+1]   <= pop_ff[g];
         pcpu_ff[g+1]  <= pcpu_ff[g];
         pnice_ff[g+1] <= pnice_ff[g];
         palt_ff[g+1]  <= palt_ff[g];
         pden_ff[g+1]  <= pden_ff[g];
         prem_ff[g+1]  <= fits ? (prem_ff[g] - trial) : prem_ff[g];
         pquo_ff[g+1]  <= pquo_ff[g] | (fits ? DIV_STEPS'(1) << Bit : '0);
      end
   end

   // Multiply the decay factor by recent CPU.
   assign mul_prod_in = $signed({1'b0, pquo_ff[DIV_STEPS]}) * pcpu_ff[DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= pv_ff[DIV_STEPS];
      end
      mul_op_ff   <= pop_ff[DIV_STEPS];
      mul_nice_ff <= pnice_ff[DIV_STEPS];
      mul_alt_ff  <= palt_ff[DIV_STEPS];
      mul_prod_ff <= mul_prod_in;
   end

   // Scale the product back with truncation toward zero and add nice in fixed point.
   always_comb begin
      scaled_adj = mul_prod_ff + (mul_prod_ff[PROD_W-1] ? PROD_W'(FP_ONE - 1) : '0);
      recent_val = scaled_adj[FP_SHIFT+VAL_W-1:FP_SHIFT]
                   + {{(VAL_W-NICE_W-FP_SHIFT){mul_nice_ff[NICE_W-1]}}, mul_nice_ff,
                      {FP_SHIFT{1'b0}}};
      case (mul_op_ff)
         OP_RECENT: value_in = recent_val;
         default:   value_in = mul_alt_ff;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= mul_valid_ff;
      end
      rsp_value_ff <= value_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = $signed(rsp_value_ff);

   // Every taken item gives a result after the fixed latency.
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("item taken without a result after the pipeline latency");

   // No result appears without an item taken at the matching edge.
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result without a matching item");

   // The divider leaves a remainder below the divisor.
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      pv_ff[DIV_STEPS] |-> (prem_ff[DIV_STEPS] < REM_W'(pden_ff[DIV_STEPS])))
      else $error("divider remainder not below divisor");

   // An unused operation code in the multiply stage yields zero in the output register.
   a_unused_op_zero: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff && mul_op_ff == OP_NONE) |=> (rsp_value_ff == '0))
      else $error("unused operation gave a nonzero value");

endmodule

`default_nettype wire

// File: tb/mlfq_sched_stats_unit_core_test.sv
`timescale 1ns / 100ps

// Scoreboard: works out the expected value of each item taken by the unit and
// checks the values that come back, in order.
class sched_scoreboard;
   logic signed [31:0] pending_values[$];
   int                 fail_count;

   function new();
      fail_count = 0;
   endfunction

   // Predicts the value for one item at 64 bits, then wraps it to 32 bits.
   // Every division truncates toward zero, as SystemVerilog integer division does.
   function logic signed [31:0] predict_sched_value(mlfq_pkg::op_type op,
                                                    logic [23:0] load_level,
                                                    logic signed [31:0] cpu_usage,
                                                    logic signed [5:0] nice_value,
                                                    logic [9:0] ready_count);
      longint la_l;
      longint cpu_l;
      longint nice_l;
      longint rc_l;
      longint twice_la;
      longint decay;
      longint numer;
      longint sum;
      la_l   = load_level;
      cpu_l  = cpu_usage;
      nice_l = nice_value;
      rc_l   = ready_count;
      sum    = 0;
      case (op)
         mlfq_pkg::OP_LOAD: begin
            sum = (mlfq_pkg::LOAD_DECAY * la_l) / mlfq_pkg::FP_ONE
                  + mlfq_pkg::LOAD_GAIN * rc_l;
         end
         mlfq_pkg::OP_RECENT: begin
            twice_la = 2 * la_l;
            decay    = (twice_la * mlfq_pkg::FP_ONE) / (twice_la + mlfq_pkg::FP_ONE);
            sum      = (decay * cpu_l) / mlfq_pkg::FP_ONE + nice_l * mlfq_pkg::FP_ONE;
         end
         mlfq_pkg::OP_PRIO: begin
            numer = (mlfq_pkg::PRIO_BASE - 2 * nice_l) * mlfq_pkg::FP_ONE - cpu_l / 4;
            sum   = numer / mlfq_pkg::FP_ONE;
         end
         default: begin
            sum = 0;
         end
      endcase
      return sum[31:0];
   endfunction

   // Notes an item that the unit has taken.
   function void note_item(mlfq_pkg::op_type op, logic [23:0] load_level,
                           logic signed [31:0] cpu_usage, logic signed [5:0] nice_value,
                           logic [9:0] ready_count);
      pending_values.push_back(predict_sched_value(op, load_level, cpu_usage,
                                                   nice_value, ready_count));
   endfunction

   // Checks one result against the oldest expected value.
   function void check_value(logic signed [31:0] actual);
      logic signed [31:0] wanted;
      if (pending_values.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
         fail_count++;
      end else begin
         wanted = pending_values.pop_front();
         if (actual !== wanted) begin
            $display("%0t: value mismatch, expected %0d (%h), actual %0d (%h)",
                     $time, wanted, wanted, actual, actual);
            fail_count++;
         end
      end
   endfunction
endclass

module mlfq_sched_stats_unit_core_test;
   import mlfq_pkg::*;

   localparam int RANDOM_ITEMS = 850;
   localparam int STALL_LIMIT  = 2000;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     start           = 1'b0;
   logic                     busy;
   logic [1:0]               req_type        = '0;
   logic [LA_W-1:0]          req_load_level  = '0;
   logic signed [CPU_W-1:0]  req_cpu_usage   = '0;
   logic signed [NICE_W-1:0] req_nice_value  = '0;
   logic [RC_W-1:0]          req_ready_count = '0;
   logic                     rsp_strobe;
   logic signed [VAL_W-1:0]  rsp_value;

   sched_scoreboard sb = new();
   int              stall_cycles = 0;

   mlfq_sched_stats_unit_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_load_level  (req_load_level),
      .req_cpu_usage   (req_cpu_usage),
      .req_nice_value  (req_nice_value),
      .req_ready_count (req_ready_count),
      .rsp_strobe      (rsp_strobe),
      .rsp_value       (rsp_value)
   );

   always #1 clock = ~clock;

   // Monitor: notes each item taken and checks each result shown.
   always @(posedge clock) begin
      if (start && !busy && !reset) begin
         sb.note_item(op_type'(req_type), req_load_level, req_cpu_usage,
                      req_nice_value, req_ready_count);
      end
      if (!reset && rsp_strobe === 1'b1) begin
         sb.check_value(rsp_value);
      end
   end

   // Watchdog: ends the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Presents one item and waits for the edge that takes it.
   task automatic send_item(op_type op, logic [23:0] la, logic signed [31:0] cpu,
                            logic signed [5:0] nice, logic [9:0] rc);
      logic was_busy;
      start           <= 1'b1;
      req_type        <= op;
      req_load_level  <= la;
      req_cpu_usage   <= cpu;
      req_nice_value  <= nice;
      req_ready_count <= rc;
      forever begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
         if (!was_busy) break;
      end
   endtask

   // Holds the input channel idle for a number of cycles.
   task automatic idle_cycles(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Holds the input channel idle until every expected value has come back.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_values.size() != 0) @(posedge clock);
   endtask

   // Builds one random item, weighted towards realistic scheduler values.
   task automatic send_random_item();
      op_type             op;
      logic [23:0]        la;
      logic signed [31:0] cpu;
      logic signed [5:0]  nice;
      logic [9:0]         rc;
      op = ($urandom_range(0, 19) == 0) ? OP_NONE : op_type'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
         0: la = 24'($urandom_range(0, 4 * FP_ONE));
         1: la = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'hFFFFFF;
         default: la = 24'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: cpu = int'($urandom_range(0, 400 * FP_ONE)) - 200 * FP_ONE;
         1: cpu = int'($urandom_range(0, 32)) - 16;
         default: cpu = $urandom;
      endcase
      if ($urandom_range(0, 7) == 0) begin
         nice = 6'($urandom);
      end else begin
         nice = 6'(int'($urandom_range(0, 40)) - 20);
      end
      rc = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 10)) : 10'($urandom);
      send_item(op, la, cpu, nice, rc);
   endtask

   initial begin
      int sent;
      int burst_len;
      int gap_kind;

      // Hold synchronous reset, then release it.
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: field extremes, every operation and the unused code.
      send_item(OP_LOAD, 24'd0, 32'sd0, 6'sd0, 10'd0);
      send_item(OP_LOAD, 24'hFFFFFF, 32'sd0, 6'sd0, 10'd1023);
      send_item(OP_LOAD, 24'd1, 32'sd0, 6'sd0, 10'd1);
      send_item(OP_RECENT, 24'd0, 32'h7FFFFFFF, 6'sd0, 10'd0);
      send_item(OP_RECENT, 24'hFFFFFF, 32'h7FFFFFFF, 6'sd31, 10'd0);
      send_item(OP_RECENT, 24'hFFFFFF, 32'h80000000, -6'sd32, 10'd0);
      send_item(OP_RECENT, 24'd16384, -32'sd1, 6'sd0, 10'd0);
      send_item(OP_RECENT, 24'd8192, 32'sd1000000, -6'sd20, 10'd0);
      send_item(OP_RECENT, 24'd100, -32'sd700000, 6'sd20, 10'd0);
      send_item(OP_PRIO, 24'd0, 32'sd0, 6'sd0, 10'd0);
      send_item(OP_PRIO, 24'd0, -32'sd3, 6'sd0, 10'd0);
      send_item(OP_PRIO, 24'd0, 32'sd3, 6'sd0, 10'd0);
      send_item(OP_PRIO, 24'd0, 32'h7FFFFFFF, 6'sd31, 10'd0);
      send_item(OP_PRIO, 24'd0, 32'h80000000, -6'sd32, 10'd0);
      send_item(OP_PRIO, 24'd0, 32'sd4194304, 6'sd20, 10'd0);
      send_item(OP_PRIO, 24'd0, -32'sd4194304, -6'sd20, 10'd0);
      // The unused code must give zero whatever the other fields hold.
      send_item(OP_NONE, 24'hFFFFFF, 32'hFFFFFFFF, -6'sd1, 10'd1023);
      send_item(OP_NONE, 24'd0, 32'sd0, 6'sd0, 10'd0);
      wait_drained();

      // Random items in bursts, with gaps of varied length and some drains.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(1, 24);
         repeat (burst_len) begin
            send_random_item();
            sent++;
         end
         gap_kind = $urandom_range(0, 9);
         if (gap_kind < 3) begin
            idle_cycles(0);
         end else if (gap_kind < 8) begin
            idle_cycles($urandom_range(1, 4));
         end else if (gap_kind == 8) begin
            idle_cycles($urandom_range(5, 30));
         end else begin
            wait_drained();
         end
      end

      // Let the pipeline empty, then keep watching for stray results.
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);

      if (sb.fail_count == 0 && sb.pending_values.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
